[src/assert_macros.svh]
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only
`define LNP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included
`define LNP_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[src/lnp_pkg.sv]
`default_nettype none
package lnp_pkg;
    localparam int NUM_LANES  = 10;
    localparam int MAX_ELEMS  = 10;
    localparam int ELEM_WIDTH = 16;
    localparam int IDX_W      = $clog2(NUM_LANES);
    localparam int CNT_W      = $clog2(NUM_LANES + 1);
    localparam int S_DATA_W   = ((CNT_W + NUM_LANES * ELEM_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W   = ((1 + NUM_LANES * ELEM_WIDTH + 7) / 8) * 8;

    typedef logic signed [ELEM_WIDTH-1:0] elem_t;
    typedef elem_t [NUM_LANES-1:0]        vec_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    typedef struct packed {
        logic hit;
        idx_t idx;
    } pick_t;
endpackage
`default_nettype wire

[src/lnp_lane.sv]
`default_nettype none
module lnp_lane
    import lnp_pkg::*;
(
    input  wire elem_t a,
    input  wire elem_t b,
    input  wire logic  en,
    output logic       less
);
    assign less = en && (a < b);
endmodule
`default_nettype wire

[src/lnp_merge.sv]
`default_nettype none
module lnp_merge
    import lnp_pkg::*;
(
    input  wire logic [NUM_LANES-1:0] flags,
    output pick_t                     pick
);
    // highest flagged lane wins
    always_comb begin
        pick.hit = 1'b0;
        pick.idx = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            if (flags[k]) begin
                pick.hit = 1'b1;
                pick.idx = IDX_W'(k);
            end
        end
    end
endmodule
`default_nettype wire

[src/lnp_permute.sv]
`default_nettype none
module lnp_permute
    import lnp_pkg::*;
(
    input  wire vec_t  vec,
    input  wire cnt_t  cnt,
    input  wire pick_t piv,
    input  wire idx_t  swp,
    output vec_t       res
);
    always_comb begin
        logic [CNT_W:0] m;
        m = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            res[k] = vec[k];
            if (CNT_W'(k) < cnt) begin
                if (piv.hit) begin
                    if (IDX_W'(k) == piv.idx) begin
                        res[k] = vec[swp];
                    end else if (IDX_W'(k) > piv.idx) begin
                        // mirrored position inside the reversed suffix
                        m = {1'b0, cnt} + (CNT_W+1)'(piv.idx) - (CNT_W+1)'(k);
                        if (m[IDX_W-1:0] == swp) begin
                            res[k] = vec[piv.idx];
                        end else begin
                            res[k] = vec[m[IDX_W-1:0]];
                        end
                    end
                end else begin
                    m = {1'b0, cnt} - (CNT_W+1)'(1) - (CNT_W+1)'(k);
                    res[k] = vec[m[IDX_W-1:0]];
                end
            end
        end
    end
endmodule
`default_nettype wire

[src/lexicographic_next_permutation.sv]
// Path: an accepted s_ beat is registered in stages a, b, c and d in turn; the stage d valid drives m_tvalid.
// Throughput: one beat per cycle; stages stall independently on m_tready.
// Stages: lane ascent compare, pivot merge, successor search, output permute.
// Reset: synchronous active-low aresetn clears all stage valids; no payload reset.
`default_nettype none
`include "assert_macros.svh"
module lexicographic_next_permutation
    import lnp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    // active_count[3:0], elem_in_0..elem_in_9 (16 bits each), zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    // found_next[0], elem_out_0..elem_out_9 (16 bits each), zero pad
    output      logic [M_DATA_W-1:0] m_tdata
);
    logic a_rdy, b_rdy, c_rdy, d_rdy;
    logic a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;

    vec_t  in_vec;
    cnt_t  in_raw, in_n;
    logic [NUM_LANES-1:0] in_asc;

    vec_t  a_vec_reg;
    cnt_t  a_n_reg;
    logic [NUM_LANES-1:0] a_asc_reg;

    pick_t piv_next;
    vec_t  b_vec_reg;
    cnt_t  b_n_reg;
    pick_t b_piv_reg;

    elem_t piv_val;
    logic [NUM_LANES-1:0] gt_flags;
    pick_t swp_next;
    vec_t  c_vec_reg;
    cnt_t  c_n_reg;
    pick_t c_piv_reg;
    idx_t  c_swp_reg;

    vec_t  res_next;
    vec_t  d_vec_reg;
    logic  d_found_reg;

    assign d_rdy    = !d_vld_reg || m_tready;
    assign c_rdy    = !c_vld_reg || d_rdy;
    assign b_rdy    = !b_vld_reg || c_rdy;
    assign a_rdy    = !a_vld_reg || b_rdy;
    assign s_tready = a_rdy;

    // input unpack and lane ascent compares
    assign in_raw = s_tdata[CNT_W-1:0];
    assign in_n   = (in_raw > CNT_W'(MAX_ELEMS)) ? CNT_W'(MAX_ELEMS) : in_raw;

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_unpack
        assign in_vec[k] = s_tdata[CNT_W + k*ELEM_WIDTH +: ELEM_WIDTH];
    end

    for (genvar k = 0; k < NUM_LANES - 1; k++) begin : g_asc
        lnp_lane u_asc (
            .a    (in_vec[k]),
            .b    (in_vec[k+1]),
            .en   (CNT_W'(k + 1) < in_n),
            .less (in_asc[k])
        );
    end
    assign in_asc[NUM_LANES-1] = 1'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (a_rdy) begin
            a_vld_reg <= s_tvalid;
        end
        if (a_rdy && s_tvalid) begin
            a_vec_reg <= in_vec;
            a_n_reg   <= in_n;
            a_asc_reg <= in_asc;
        end
    end

    // pivot: rightmost ascent
    lnp_merge u_piv (
        .flags (a_asc_reg),
        .pick  (piv_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (b_rdy) begin
            b_vld_reg <= a_vld_reg;
        end
        if (b_rdy && a_vld_reg) begin
            b_vec_reg <= a_vec_reg;
            b_n_reg   <= a_n_reg;
            b_piv_reg <= piv_next;
        end
    end

    // successor: rightmost lane above the pivot value
    assign piv_val = b_vec_reg[b_piv_reg.idx];

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_gt
        lnp_lane u_gt (
            .a    (piv_val),
            .b    (b_vec_reg[k]),
            .en   (b_piv_reg.hit && (IDX_W'(k) > b_piv_reg.idx) && (CNT_W'(k) < b_n_reg)),
            .less (gt_flags[k])
        );
    end

    lnp_merge u_swp (
        .flags (gt_flags),
        .pick  (swp_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (c_rdy) begin
            c_vld_reg <= b_vld_reg;
        end
        if (c_rdy && b_vld_reg) begin
            c_vec_reg <= b_vec_reg;
            c_n_reg   <= b_n_reg;
            c_piv_reg <= b_piv_reg;
            c_swp_reg <= swp_next.idx;
        end
    end

    lnp_permute u_perm (
        .vec (c_vec_reg),
        .cnt (c_n_reg),
        .piv (c_piv_reg),
        .swp (c_swp_reg),
        .res (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (d_rdy) begin
            d_vld_reg <= c_vld_reg;
        end
        if (d_rdy && c_vld_reg) begin
            d_vec_reg   <= res_next;
            d_found_reg <= c_piv_reg.hit;
        end
    end

    assign m_tvalid = d_vld_reg;
    assign m_tdata  = M_DATA_W'({d_vec_reg, d_found_reg});

    `LNP_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid && !c_vld_reg && !a_vld_reg, "valid after reset")
    `LNP_ASSERT(a_count_sat, a_vld_reg |-> a_n_reg <= CNT_W'(MAX_ELEMS), "count not saturated")
    `LNP_ASSERT(a_pivot_range, b_vld_reg && b_piv_reg.hit |-> (CNT_W'(b_piv_reg.idx) + CNT_W'(1)) < b_n_reg, "pivot out of range")
    `LNP_ASSERT(a_swap_range, c_vld_reg && c_piv_reg.hit |-> (c_swp_reg > c_piv_reg.idx) && (CNT_W'(c_swp_reg) < c_n_reg), "swap lane out of range")
endmodule
`default_nettype wire
